/* rtl/usb_mass_storage_iface_finder_assert.svh */
// assertion macros shared by the rtl files
// both expect clk and arst_n in scope
`ifndef USB_MASS_STORAGE_IFACE_FINDER_ASSERT_SVH
`define USB_MASS_STORAGE_IFACE_FINDER_ASSERT_SVH

// same-cycle implication
`define USBMSF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define USBMSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/usbmsf_pkg.sv */
package usbmsf_pkg;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_IFACE  = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	localparam logic [7:0] TYPE_INTERFACE = 8'h04;
	localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
	localparam logic [7:0] OFF_CLASS      = 8'd5;
	localparam logic [7:0] OFF_ADDRESS    = 8'd2;
	localparam logic [7:0] OFF_ATTRIB     = 8'd3;
	localparam logic [1:0] XFER_BULK      = 2'b10;
	localparam logic [7:0] CLASS_RESET    = 8'h08;

	typedef struct packed {
		logic       found;
		logic       in_ok;
		logic [3:0] in_ep;
		logic       out_ok;
		logic [3:0] out_ep;
	} result_t;

endpackage

/* rtl/usbmsf_scan.sv */
`include "usb_mass_storage_iface_finder_assert.svh"

module usbmsf_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            byte_in,
	input  logic                  last_in,
	input  logic [7:0]            match_class,
	output usbmsf_pkg::result_t   result
);

	usbmsf_pkg::phase_t phase_q, phase_d;
	logic [7:0] offset_q, offset_d;
	logic [7:0] length_q, length_d;
	logic [7:0] type_q, type_d;
	logic [7:0] addr_q, addr_d;
	logic       found_q, found_d;
	logic       in_seen_q, in_seen_d;
	logic [3:0] in_num_q, in_num_d;
	logic       out_seen_q, out_seen_d;
	logic [3:0] out_num_q, out_num_d;

	logic       active;
	logic [7:0] len_use;
	logic       stop_zero;
	logic       stop_iface;
	logic       class_hit;
	logic       bulk_hit;

	assign active    = (phase_q == usbmsf_pkg::PH_SEARCH) || (phase_q == usbmsf_pkg::PH_IFACE);
	assign len_use   = (offset_q == 8'd0) ? byte_in : length_q;
	assign stop_zero = (offset_q == 8'd0) && (byte_in == 8'd0);
	assign stop_iface = (offset_q == 8'd1) && (phase_q == usbmsf_pkg::PH_IFACE)
		&& (byte_in == usbmsf_pkg::TYPE_INTERFACE);
	assign class_hit = (phase_q == usbmsf_pkg::PH_SEARCH)
		&& (type_q == usbmsf_pkg::TYPE_INTERFACE)
		&& (offset_q == usbmsf_pkg::OFF_CLASS) && (byte_in == match_class);
	assign bulk_hit  = (phase_q == usbmsf_pkg::PH_IFACE)
		&& (type_q == usbmsf_pkg::TYPE_ENDPOINT)
		&& (offset_q == usbmsf_pkg::OFF_ATTRIB) && (byte_in[1:0] == usbmsf_pkg::XFER_BULK);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (active) begin
			if (stop_zero || stop_iface) begin
				phase_d = usbmsf_pkg::PH_DONE;
			end else if (class_hit) begin
				phase_d = usbmsf_pkg::PH_IFACE;
			end
		end
	end

	// descriptor tracking and endpoint capture
	always_comb begin
		offset_d   = offset_q;
		length_d   = length_q;
		type_d     = type_q;
		addr_d     = addr_q;
		found_d    = found_q;
		in_seen_d  = in_seen_q;
		in_num_d   = in_num_q;
		out_seen_d = out_seen_q;
		out_num_d  = out_num_q;
		if (active) begin
			if (offset_q == 8'd0) begin
				length_d = byte_in;
				type_d   = 8'd0;
				addr_d   = 8'd0;
			end else if (offset_q == 8'd1) begin
				type_d = byte_in;
			end else begin
				if (class_hit) begin
					found_d = 1'b1;
				end
				if ((phase_q == usbmsf_pkg::PH_IFACE) && (type_q == usbmsf_pkg::TYPE_ENDPOINT)
					&& (offset_q == usbmsf_pkg::OFF_ADDRESS)) begin
					addr_d = byte_in;
				end
				if (bulk_hit) begin
					if (addr_q[7]) begin
						if (!in_seen_q) begin
							in_seen_d = 1'b1;
							in_num_d  = addr_q[3:0];
						end
					end else if (!out_seen_q) begin
						out_seen_d = 1'b1;
						out_num_d  = addr_q[3:0];
					end
				end
			end
			// offset holds where the scan stops
			if (!(stop_zero || stop_iface)) begin
				if (({1'b0, offset_q} + 9'd1) >= {1'b0, len_use}) begin
					offset_d = 8'd0;
				end else begin
					offset_d = offset_q + 8'd1;
				end
			end
		end
	end

	// result as seen after this byte
	always_comb begin
		result.found  = found_d;
		result.in_ok  = in_seen_d;
		result.in_ep  = in_seen_d ? in_num_d : 4'd0;
		result.out_ok = out_seen_d;
		result.out_ep = out_seen_d ? out_num_d : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= usbmsf_pkg::PH_SEARCH;
			offset_q   <= 8'd0;
			length_q   <= 8'd0;
			type_q     <= 8'd0;
			addr_q     <= 8'd0;
			found_q    <= 1'b0;
			in_seen_q  <= 1'b0;
			in_num_q   <= 4'd0;
			out_seen_q <= 1'b0;
			out_num_q  <= 4'd0;
		end else if (take) begin
			if (last_in) begin
				phase_q    <= usbmsf_pkg::PH_SEARCH;
				offset_q   <= 8'd0;
				length_q   <= 8'd0;
				type_q     <= 8'd0;
				addr_q     <= 8'd0;
				found_q    <= 1'b0;
				in_seen_q  <= 1'b0;
				in_num_q   <= 4'd0;
				out_seen_q <= 1'b0;
				out_num_q  <= 4'd0;
			end else begin
				phase_q    <= phase_d;
				offset_q   <= offset_d;
				length_q   <= length_d;
				type_q     <= type_d;
				addr_q     <= addr_d;
				found_q    <= found_d;
				in_seen_q  <= in_seen_d;
				in_num_q   <= in_num_d;
				out_seen_q <= out_seen_d;
				out_num_q  <= out_num_d;
			end
		end
	end

	`USBMSF_ASSERT_SAME(a_iface_implies_found, phase_q == usbmsf_pkg::PH_IFACE, found_q,
		"in interface phase without a class match")
	`USBMSF_ASSERT_SAME(a_ep_needs_found, in_seen_q || out_seen_q, found_q,
		"endpoint recorded before a matching interface")

endmodule

/* rtl/usb_mass_storage_iface_finder.sv */
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// desc      | desc_valid / desc_ready   | desc_byte, is_last
// result    | res_valid / res_ready     | iface_found, in_valid, in_endpoint,
//           |                           | out_valid, out_endpoint
// cfg       | cfg_wr_en (no wait)       | cfg_wr_data -> match_class
//
// one descriptor byte per cycle sustained; a byte is scanned the cycle after its transfer
// a result appears on the result port once the is_last byte leaves the input register
// the single-entry result register lets bytes of the next set flow while a result waits
// only an is_last byte stalls, and only while the result register is full and not taken
// arst_n clears the scan state, both valid flags and sets match_class to mass storage
`include "usb_mass_storage_iface_finder_assert.svh"

module usb_mass_storage_iface_finder (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	// descriptor byte stream
	input  logic       desc_valid,
	output logic       desc_ready,
	input  logic [7:0] desc_byte,
	input  logic       is_last,
	// scan result
	output logic       res_valid,
	input  logic       res_ready,
	output logic       iface_found,
	output logic       in_valid,
	output logic [3:0] in_endpoint,
	output logic       out_valid,
	output logic [3:0] out_endpoint
);

	logic [7:0] match_class_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;

	// result stage
	logic                valid_s2;
	usbmsf_pkg::result_t res_s2;
	usbmsf_pkg::result_t scan_res;

	// class code register, to be written only between sets; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_class_q <= usbmsf_pkg::CLASS_RESET;
		end else if (cfg_wr_en) begin
			match_class_q <= cfg_wr_data;
		end
	end

	// a byte moves on unless it closes a set and the result slot is still occupied
	assign adv_s1     = valid_s1 && (!last_s1 || !valid_s2 || res_ready);
	assign desc_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (desc_valid && desc_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the input stage needs no reset
	always_ff @(posedge clk) begin
		if (desc_valid && desc_ready) begin
			byte_s1 <= desc_byte;
			last_s1 <= is_last;
		end
	end

	// descriptor walker: state is updated once per byte leaving the input stage
	usbmsf_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (adv_s1),
		.byte_in     (byte_s1),
		.last_in     (last_s1),
		.match_class (match_class_q),
		.result      (scan_res)
	);

	// result register, loaded only by the closing byte of a set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_s2 <= scan_res;
		end
	end

	assign res_valid    = valid_s2;
	assign iface_found  = res_s2.found;
	assign in_valid     = res_s2.in_ok;
	assign in_endpoint  = res_s2.in_ep;
	assign out_valid    = res_s2.out_ok;
	assign out_endpoint = res_s2.out_ep;

	// a waiting result must never be overwritten by the next set's closing byte
	`USBMSF_ASSERT_SAME(a_no_overwrite, valid_s1 && last_s1 && valid_s2 && !res_ready, !adv_s1,
		"closing byte advanced over a pending result")
	// the closing byte always produces a result in the next cycle
	`USBMSF_ASSERT_NEXT(a_last_gives_result, adv_s1 && last_s1, valid_s2,
		"closing byte did not load the result register")
	// endpoint numbers read as zero when their direction was not found
	`USBMSF_ASSERT_SAME(a_zero_ep, valid_s2 && !res_s2.in_ok, res_s2.in_ep == 4'd0,
		"in endpoint number nonzero without a bulk in endpoint")
	`USBMSF_ASSERT_SAME(a_zero_ep_out, valid_s2 && !res_s2.out_ok, res_s2.out_ep == 4'd0,
		"out endpoint number nonzero without a bulk out endpoint")

endmodule
